/* sv/tcpq_pkg.sv */
// Shared types and constants of the two-class priority ticket queue.
`default_nettype none
package tcpq_pkg;

  localparam int unsigned NUM_OUT_W   = 16;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [CFG_DATA_W-1:0] PRIO_START_RESET = 16'd300;

  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_CALL = 2'd1;
  localparam logic [1:0] CMD_LIST = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_COMMON_START   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_PRIORITY_START = 1'b1;

  localparam logic [2:0] ST_ADDED      = 3'd0;
  localparam logic [2:0] ST_CALLED     = 3'd1;
  localparam logic [2:0] ST_CALL_EMPTY = 3'd2;
  localparam logic [2:0] ST_ADD_FULL   = 3'd3;
  localparam logic [2:0] ST_LIST_ENTRY = 3'd4;
  localparam logic [2:0] ST_LIST_EMPTY = 3'd5;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_CALL = 2'd1,
    OP_LIST = 2'd2
  } tcpq_op_code_t;

  typedef struct packed {
    tcpq_op_code_t code;
    logic          cls;
  } tcpq_op_t;

  typedef struct packed {
    logic     valid;
    tcpq_op_t op;
  } tcpq_opq_t;

  typedef struct packed {
    logic                   wr;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
  } tcpq_cfg_t;

endpackage
`default_nettype wire

/* sv/tcpq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tcpq_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

/* sv/tcpq_front.sv */
// Front end: accepts commands, decodes them and holds them in a short queue.
`default_nettype none
module tcpq_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          in_cmd,
  input  wire logic                in_cls,
  output tcpq_pkg::tcpq_opq_t      opq,
  input  wire logic                op_pop
);
  import tcpq_pkg::*;

  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  tcpq_op_t          q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push;
  logic              do_pop;
  tcpq_op_t          dec_op;
  logic              dec_ok;

  always_comb begin
    dec_op.cls  = in_cls;
    dec_op.code = OP_ADD;
    dec_ok      = 1'b1;
    unique case (in_cmd)
      CMD_ADD:  dec_op.code = OP_ADD;
      CMD_CALL: dec_op.code = OP_CALL;
      CMD_LIST: dec_op.code = OP_LIST;
      default:  dec_ok      = 1'b0;
    endcase
  end

  assign in_ready  = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign push      = in_valid && in_ready && dec_ok;
  assign do_pop    = op_pop && (cnt_r != '0);
  assign opq.valid = (cnt_r != '0);
  assign opq.op    = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push   ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec_op;
    end
  end

endmodule
`default_nettype wire

/* sv/tcpq_back.sv */
// Back end: class FIFOs, ticket counters, command sequencer and result register.
`default_nettype none
module tcpq_back #(
  parameter int unsigned CLASS_DEPTH  = 16,
  parameter int unsigned NUMBER_WIDTH = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire tcpq_pkg::tcpq_opq_t             opq,
  output logic                                 op_pop,
  input  wire tcpq_pkg::tcpq_cfg_t             cfg,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [2:0]                           out_status,
  output logic                                 out_cls,
  output logic [tcpq_pkg::NUM_OUT_W-1:0]       out_num,
  output logic                                 out_last
);
  import tcpq_pkg::*;

  localparam int unsigned PTR_W = $clog2(CLASS_DEPTH);
  localparam int unsigned CNT_W = $clog2(CLASS_DEPTH + 1);
  localparam int unsigned NW    = NUMBER_WIDTH;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CALL  = 4'b0010,
    S_LREAD = 4'b0100,
    S_LEMIT = 4'b1000
  } tcpq_state_t;

  tcpq_state_t      state_r, state_nxt;
  logic [PTR_W-1:0] p_rd_r, p_rd_nxt, p_wr_r, p_wr_nxt;
  logic [PTR_W-1:0] c_rd_r, c_rd_nxt, c_wr_r, c_wr_nxt;
  logic [CNT_W-1:0] p_cnt_r, p_cnt_nxt, c_cnt_r, c_cnt_nxt;
  logic [NW-1:0]    p_ctr_r, p_ctr_nxt, c_ctr_r, c_ctr_nxt;
  logic             cur_cls_r, cur_cls_nxt;
  logic [PTR_W-1:0] lst_addr_r, lst_addr_nxt;
  logic [CNT_W-1:0] lst_left_r, lst_left_nxt;

  logic             out_valid_r;
  logic [2:0]       out_status_r;
  logic             out_cls_r;
  logic [NW-1:0]    out_num_r;
  logic             out_last_r;

  logic             out_free;
  logic             emit;
  logic [2:0]       emit_status;
  logic             emit_cls;
  logic [NW-1:0]    emit_num;
  logic             emit_last;
  logic             lst_last;

  logic             rd_req, rd_cls;
  logic [PTR_W-1:0] rd_addr;
  logic             wr_p, wr_c;
  logic [PTR_W-1:0] wr_addr;
  logic [NW-1:0]    wr_data;
  logic [NW-1:0]    p_rd_data, c_rd_data, rd_data_sel;
  logic [NW-1:0]    p_next_num, c_next_num;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(CLASS_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign out_free    = !out_valid_r || out_ready;
  assign rd_data_sel = cur_cls_r ? p_rd_data : c_rd_data;
  assign p_next_num  = p_ctr_r + NW'(1);
  assign c_next_num  = c_ctr_r + NW'(1);
  assign lst_last    = (lst_left_r == CNT_W'(1)) && (!cur_cls_r || (c_cnt_r == '0));

  always_comb begin
    state_nxt    = state_r;
    p_rd_nxt     = p_rd_r;
    p_wr_nxt     = p_wr_r;
    c_rd_nxt     = c_rd_r;
    c_wr_nxt     = c_wr_r;
    p_cnt_nxt    = p_cnt_r;
    c_cnt_nxt    = c_cnt_r;
    p_ctr_nxt    = p_ctr_r;
    c_ctr_nxt    = c_ctr_r;
    cur_cls_nxt  = cur_cls_r;
    lst_addr_nxt = lst_addr_r;
    lst_left_nxt = lst_left_r;
    op_pop       = 1'b0;
    emit         = 1'b0;
    emit_status  = ST_ADDED;
    emit_cls     = 1'b0;
    emit_num     = '0;
    emit_last    = 1'b1;
    rd_req       = 1'b0;
    rd_cls       = 1'b0;
    rd_addr      = '0;
    wr_p         = 1'b0;
    wr_c         = 1'b0;
    wr_addr      = '0;
    wr_data      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (opq.valid && out_free) begin
          op_pop = 1'b1;
          unique case (opq.op.code)
            OP_ADD: begin
              emit     = 1'b1;
              emit_cls = opq.op.cls;
              if (opq.op.cls) begin
                if (p_cnt_r == CNT_W'(CLASS_DEPTH)) begin
                  emit_status = ST_ADD_FULL;
                end else begin
                  wr_p        = 1'b1;
                  wr_addr     = p_wr_r;
                  wr_data     = p_next_num;
                  p_wr_nxt    = ptr_inc(p_wr_r);
                  p_cnt_nxt   = p_cnt_r + CNT_W'(1);
                  p_ctr_nxt   = p_next_num;
                  emit_status = ST_ADDED;
                  emit_num    = p_next_num;
                end
              end else begin
                if (c_cnt_r == CNT_W'(CLASS_DEPTH)) begin
                  emit_status = ST_ADD_FULL;
                end else begin
                  wr_c        = 1'b1;
                  wr_addr     = c_wr_r;
                  wr_data     = c_next_num;
                  c_wr_nxt    = ptr_inc(c_wr_r);
                  c_cnt_nxt   = c_cnt_r + CNT_W'(1);
                  c_ctr_nxt   = c_next_num;
                  emit_status = ST_ADDED;
                  emit_num    = c_next_num;
                end
              end
            end
            OP_CALL: begin
              if (p_cnt_r != '0) begin
                rd_req      = 1'b1;
                rd_cls      = 1'b1;
                rd_addr     = p_rd_r;
                p_rd_nxt    = ptr_inc(p_rd_r);
                p_cnt_nxt   = p_cnt_r - CNT_W'(1);
                cur_cls_nxt = 1'b1;
                state_nxt   = S_CALL;
              end else if (c_cnt_r != '0) begin
                rd_req      = 1'b1;
                rd_cls      = 1'b0;
                rd_addr     = c_rd_r;
                c_rd_nxt    = ptr_inc(c_rd_r);
                c_cnt_nxt   = c_cnt_r - CNT_W'(1);
                cur_cls_nxt = 1'b0;
                state_nxt   = S_CALL;
              end else begin
                emit        = 1'b1;
                emit_status = ST_CALL_EMPTY;
              end
            end
            OP_LIST: begin
              if (p_cnt_r != '0) begin
                cur_cls_nxt  = 1'b1;
                lst_addr_nxt = p_rd_r;
                lst_left_nxt = p_cnt_r;
                state_nxt    = S_LREAD;
              end else if (c_cnt_r != '0) begin
                cur_cls_nxt  = 1'b0;
                lst_addr_nxt = c_rd_r;
                lst_left_nxt = c_cnt_r;
                state_nxt    = S_LREAD;
              end else begin
                emit        = 1'b1;
                emit_status = ST_LIST_EMPTY;
              end
            end
            default: begin
              op_pop = 1'b1;
            end
          endcase
        end
      end
      S_CALL: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_status = ST_CALLED;
          emit_cls    = cur_cls_r;
          emit_num    = rd_data_sel;
          state_nxt   = S_IDLE;
        end
      end
      S_LREAD: begin
        rd_req    = 1'b1;
        rd_cls    = cur_cls_r;
        rd_addr   = lst_addr_r;
        state_nxt = S_LEMIT;
      end
      S_LEMIT: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_status = ST_LIST_ENTRY;
          emit_cls    = cur_cls_r;
          emit_num    = rd_data_sel;
          emit_last   = lst_last;
          if (lst_last) begin
            state_nxt = S_IDLE;
          end else if (lst_left_r == CNT_W'(1)) begin
            cur_cls_nxt  = 1'b0;
            lst_addr_nxt = c_rd_r;
            lst_left_nxt = c_cnt_r;
            state_nxt    = S_LREAD;
          end else begin
            lst_addr_nxt = ptr_inc(lst_addr_r);
            lst_left_nxt = lst_left_r - CNT_W'(1);
            state_nxt    = S_LREAD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg.wr) begin
      unique case (cfg.index)
        REG_COMMON_START:   c_ctr_nxt = NW'(cfg.data);
        REG_PRIORITY_START: p_ctr_nxt = NW'(cfg.data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      p_rd_r      <= '0;
      p_wr_r      <= '0;
      c_rd_r      <= '0;
      c_wr_r      <= '0;
      p_cnt_r     <= '0;
      c_cnt_r     <= '0;
      p_ctr_r     <= NW'(PRIO_START_RESET);
      c_ctr_r     <= '0;
      cur_cls_r   <= 1'b0;
      lst_addr_r  <= '0;
      lst_left_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      p_rd_r      <= p_rd_nxt;
      p_wr_r      <= p_wr_nxt;
      c_rd_r      <= c_rd_nxt;
      c_wr_r      <= c_wr_nxt;
      p_cnt_r     <= p_cnt_nxt;
      c_cnt_r     <= c_cnt_nxt;
      p_ctr_r     <= p_ctr_nxt;
      c_ctr_r     <= c_ctr_nxt;
      cur_cls_r   <= cur_cls_nxt;
      lst_addr_r  <= lst_addr_nxt;
      lst_left_r  <= lst_left_nxt;
      out_valid_r <= emit || (out_valid_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_status_r <= emit_status;
      out_cls_r    <= emit_cls;
      out_num_r    <= emit_num;
      out_last_r   <= emit_last;
    end
  end

  tcpq_ram #(
    .WIDTH (NW),
    .DEPTH (CLASS_DEPTH)
  ) u_prio_ram (
    .clk     (clk),
    .wr_en   (wr_p),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_req && rd_cls),
    .rd_addr (rd_addr),
    .rd_data (p_rd_data)
  );

  tcpq_ram #(
    .WIDTH (NW),
    .DEPTH (CLASS_DEPTH)
  ) u_comm_ram (
    .clk     (clk),
    .wr_en   (wr_c),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_req && !rd_cls),
    .rd_addr (rd_addr),
    .rd_data (c_rd_data)
  );

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_cls    = out_cls_r;
  assign out_num    = NUM_OUT_W'(out_num_r);
  assign out_last   = out_last_r;

endmodule
`default_nettype wire

/* sv/two_class_priority_ticket_queue.sv */
// Top level of the two-class strict-priority ticket queue.
`default_nettype none
// Commands enter a four-entry command queue at up to one per cycle and are
// carried out in order by the back end, which owns the two class FIFOs (one
// RAM each, registered read) and the two ticket counters. An add, a refused
// add and a call on an empty queue are answered from the idle state; a call
// passes through a call state to wait for the registered RAM read; a list
// reads and then emits each queued ticket in turn, or answers from the idle
// state when the queue is empty. Results leave through a single output
// register; while a result waits to be taken the back end holds, and the
// command queue keeps accepting until it is full. No clearing pass follows
// reset. Configuration writes are always ready and reload the matching ticket counter.
module two_class_priority_ticket_queue #(
  parameter int unsigned CLASS_DEPTH  = 16,
  parameter int unsigned NUMBER_WIDTH = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [7:0]                          in_tdata,   // [1:0] cmd
  input  wire logic [0:0]                          in_tuser,   // [0] ticket_class
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [15:0]                              out_tdata,  // [15:0] ticket_number
  output logic [3:0]                               out_tuser,  // [2:0] status, [3] result_class
  output logic                                     out_tlast,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [tcpq_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [tcpq_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import tcpq_pkg::*;

  tcpq_opq_t            opq;
  logic                 op_pop;
  tcpq_cfg_t            cfg;
  logic [2:0]           res_status;
  logic                 res_cls;
  logic [NUM_OUT_W-1:0] res_num;

  assign cfg_ready = 1'b1;
  assign cfg.wr    = cfg_valid && cfg_ready;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  tcpq_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_cmd   (in_tdata[1:0]),
    .in_cls   (in_tuser[0]),
    .opq      (opq),
    .op_pop   (op_pop)
  );

  tcpq_back #(
    .CLASS_DEPTH  (CLASS_DEPTH),
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .opq        (opq),
    .op_pop     (op_pop),
    .cfg        (cfg),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (res_status),
    .out_cls    (res_cls),
    .out_num    (res_num),
    .out_last   (out_tlast)
  );

  assign out_tdata = res_num;
  assign out_tuser = {res_cls, res_status};

endmodule
`default_nettype wire

/* sv/tcpq_checker.sv */
// Port-level assertions for the ticket queue and the bind that attaches them.
`default_nettype none
module tcpq_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic [3:0]  out_tuser,
  input wire logic        out_tlast
);
  import tcpq_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[2:0] == ST_ADDED) || (out_tuser[2:0] == ST_CALLED)
      || (out_tuser[2:0] == ST_CALL_EMPTY) || (out_tuser[2:0] == ST_ADD_FULL)
      || (out_tuser[2:0] == ST_LIST_ENTRY) || (out_tuser[2:0] == ST_LIST_EMPTY))
    else $error("undefined status code");

  a_no_ticket: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ((out_tuser[2:0] == ST_CALL_EMPTY) || (out_tuser[2:0] == ST_ADD_FULL)
      || (out_tuser[2:0] == ST_LIST_EMPTY)) |-> (out_tdata == 16'd0) && out_tlast)
    else $error("status without ticket carries a number or misses last");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ((out_tuser[2:0] == ST_ADDED) || (out_tuser[2:0] == ST_CALLED))
      |-> out_tlast)
    else $error("single-result command without last");

endmodule

bind two_class_priority_ticket_queue tcpq_checker u_tcpq_checker (.*);
`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for the two-class priority ticket queue.
`timescale 1ns / 100ps
module tb_top;
  import tcpq_pkg::*;

  localparam int CLASS_DEPTH = 16;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic CLS_COMMON = 1'b0;
  localparam logic CLS_PRIORITY = 1'b1;
  localparam int SETTLE_CYCLES = 20;
  localparam int MAX_REPORTS = 10;
  localparam int NUM_ROWS = 17;

  typedef struct packed {
    logic [2:0]  status;
    logic        cls;
    logic [15:0] number;
    logic        last;
  } report_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        cls;
    logic        typed;
    logic [2:0]  status;
    logic        rcls;
    logic [15:0] number;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [7:0]             in_tdata;
  logic [0:0]             in_tuser;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [15:0]            out_tdata;
  logic [3:0]             out_tuser;
  logic                   out_tlast;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  logic [15:0] priority_line[$];
  logic [15:0] common_line[$];
  logic [15:0] common_ctr;
  logic [15:0] priority_ctr;
  report_t     awaited_reports[$];
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  stim_row_t directed_rows [0:NUM_ROWS-1] = '{
    '{CMD_CALL,   CLS_PRIORITY, 1'b1, ST_CALL_EMPTY, CLS_COMMON,   16'd0},
    '{CMD_LIST,   CLS_COMMON,   1'b1, ST_LIST_EMPTY, CLS_COMMON,   16'd0},
    '{CMD_ADD,    CLS_COMMON,   1'b1, ST_ADDED,      CLS_COMMON,   16'd1},
    '{CMD_ADD,    CLS_PRIORITY, 1'b1, ST_ADDED,      CLS_PRIORITY, 16'd301},
    '{CMD_ADD,    CLS_COMMON,   1'b1, ST_ADDED,      CLS_COMMON,   16'd2},
    '{CMD_ADD,    CLS_PRIORITY, 1'b1, ST_ADDED,      CLS_PRIORITY, 16'd302},
    '{CMD_LIST,   CLS_PRIORITY, 1'b0, ST_ADDED,      CLS_COMMON,   16'd0},
    '{CMD_UNUSED, CLS_COMMON,   1'b0, ST_ADDED,      CLS_COMMON,   16'd0},
    '{CMD_UNUSED, CLS_PRIORITY, 1'b0, ST_ADDED,      CLS_COMMON,   16'd0},
    '{CMD_CALL,   CLS_COMMON,   1'b1, ST_CALLED,     CLS_PRIORITY, 16'd301},
    '{CMD_ADD,    CLS_PRIORITY, 1'b1, ST_ADDED,      CLS_PRIORITY, 16'd303},
    '{CMD_CALL,   CLS_COMMON,   1'b1, ST_CALLED,     CLS_PRIORITY, 16'd302},
    '{CMD_CALL,   CLS_PRIORITY, 1'b1, ST_CALLED,     CLS_PRIORITY, 16'd303},
    '{CMD_CALL,   CLS_COMMON,   1'b1, ST_CALLED,     CLS_COMMON,   16'd1},
    '{CMD_LIST,   CLS_COMMON,   1'b0, ST_ADDED,      CLS_COMMON,   16'd0},
    '{CMD_CALL,   CLS_COMMON,   1'b1, ST_CALLED,     CLS_COMMON,   16'd2},
    '{CMD_CALL,   CLS_COMMON,   1'b1, ST_CALL_EMPTY, CLS_COMMON,   16'd0}
  };

  two_class_priority_ticket_queue #(
    .CLASS_DEPTH (CLASS_DEPTH),
    .NUMBER_WIDTH(16)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic serve_command(input logic [1:0] cmd, input logic cls);
    int total;
    int k;
    case (cmd)
      CMD_ADD: begin
        if (cls == CLS_PRIORITY) begin
          if (priority_line.size() >= CLASS_DEPTH) begin
            awaited_reports.push_back({ST_ADD_FULL, cls, 16'd0, 1'b1});
          end else begin
            priority_ctr = priority_ctr + 16'd1;
            priority_line.push_back(priority_ctr);
            awaited_reports.push_back({ST_ADDED, cls, priority_ctr, 1'b1});
          end
        end else begin
          if (common_line.size() >= CLASS_DEPTH) begin
            awaited_reports.push_back({ST_ADD_FULL, cls, 16'd0, 1'b1});
          end else begin
            common_ctr = common_ctr + 16'd1;
            common_line.push_back(common_ctr);
            awaited_reports.push_back({ST_ADDED, cls, common_ctr, 1'b1});
          end
        end
      end
      CMD_CALL: begin
        if (priority_line.size() > 0) begin
          awaited_reports.push_back({ST_CALLED, CLS_PRIORITY, priority_line.pop_front(), 1'b1});
        end else if (common_line.size() > 0) begin
          awaited_reports.push_back({ST_CALLED, CLS_COMMON, common_line.pop_front(), 1'b1});
        end else begin
          awaited_reports.push_back({ST_CALL_EMPTY, CLS_COMMON, 16'd0, 1'b1});
        end
      end
      CMD_LIST: begin
        total = priority_line.size() + common_line.size();
        k = 0;
        if (total == 0) begin
          awaited_reports.push_back({ST_LIST_EMPTY, CLS_COMMON, 16'd0, 1'b1});
        end
        foreach (priority_line[i]) begin
          k++;
          awaited_reports.push_back({ST_LIST_ENTRY, CLS_PRIORITY, priority_line[i], k == total});
        end
        foreach (common_line[i]) begin
          k++;
          awaited_reports.push_back({ST_LIST_ENTRY, CLS_COMMON, common_line[i], k == total});
        end
      end
      default: ;
    endcase
  endtask

  task automatic issue_command(input logic [1:0] cmd, input logic cls);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, cmd};
    in_tuser  <= cls;
    do @(posedge clk); while (in_tready !== 1'b1);
    serve_command(cmd, cls);
  endtask

  // Holds the input back until every awaited result has arrived, then lets
  // any ignored commands still in flight drain out of the block.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_starts(input logic [15:0] common_val, input logic [15:0] priority_val);
    cfg_valid <= 1'b1;
    cfg_index <= REG_COMMON_START;
    cfg_data  <= common_val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    common_ctr = common_val;
    cfg_index <= REG_PRIORITY_START;
    cfg_data  <= priority_val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    priority_ctr = priority_val;
    cfg_valid <= 1'b0;
  endtask

  // Bursts of adds fill the class FIFOs and bursts of calls empty them again,
  // so full and empty states are both reached; the rest is scattered noise.
  task automatic run_random_phase(input int target);
    int counted;
    int burst;
    int pick;
    logic [1:0] cmd;
    logic cls;
    counted = 0;
    repeat (CLASS_DEPTH + 2) issue_command(CMD_ADD, CLS_PRIORITY);
    repeat (CLASS_DEPTH + 2) issue_command(CMD_ADD, CLS_COMMON);
    issue_command(CMD_LIST, 1'($urandom_range(1)));
    counted = 2 * CLASS_DEPTH + 5;
    while (counted < target) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        burst = $urandom_range(1, CLASS_DEPTH + 2);
        cls = 1'($urandom_range(1));
        repeat (burst) issue_command(CMD_ADD, cls);
        counted += burst;
      end else if (pick < 65) begin
        burst = $urandom_range(1, CLASS_DEPTH + 2);
        repeat (burst) issue_command(CMD_CALL, 1'($urandom_range(1)));
        counted += burst;
      end else if (pick < 77) begin
        issue_command(CMD_LIST, 1'($urandom_range(1)));
        counted++;
      end else if (pick < 95) begin
        cmd = 2'($urandom_range(3));
        issue_command(cmd, 1'($urandom_range(1)));
        if (cmd != CMD_UNUSED) counted++;
      end else begin
        settle();
      end
    end
  endtask

  always @(posedge clk) begin
    report_t seen;
    report_t want;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      seen = {out_tuser[2:0], out_tuser[3], out_tdata, out_tlast};
      if (awaited_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("Unexpected transaction: status %0d class %0d number %0d last %0d",
                   seen.status, seen.cls, seen.number, seen.last);
      end else begin
        want = awaited_reports.pop_front();
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("Mismatch: expected status %0d class %0d number %0d last %0d, got status %0d class %0d number %0d last %0d",
                     want.status, want.cls, want.number, want.last,
                     seen.status, seen.cls, seen.number, seen.last);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL two_class_priority_ticket_queue");
    $finish;
  end

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'd0;
    in_tuser  <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_COMMON_START;
    cfg_data  <= '0;
    common_ctr   = 16'd0;
    priority_ctr = PRIO_START_RESET;
    send_idle_pct = 7;
    recv_idle_pct = 84;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      issue_command(directed_rows[r].cmd, directed_rows[r].cls);
      if (directed_rows[r].typed) begin
        void'(awaited_reports.pop_back());
        awaited_reports.push_back({directed_rows[r].status, directed_rows[r].rcls,
                                   directed_rows[r].number, 1'b1});
      end
    end
    run_random_phase(66);

    settle();
    load_starts(16'hFFFF, 16'h0000);
    send_idle_pct = 84;
    recv_idle_pct = 7;
    run_random_phase(66);

    settle();
    load_starts(16'($urandom_range(16'hFFFF)), 16'hFFFF);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_phase(66);

    settle();
    if (mismatches == 0 && awaited_reports.size() == 0) begin
      $display("PASS two_class_priority_ticket_queue");
    end else begin
      $display("FAIL two_class_priority_ticket_queue");
    end
    $finish;
  end

endmodule
